// ===== rtl/rba_pkg.sv =====
// Shared types, sizes and codes for the reference-counted page allocator.
// No dependencies; rba_ffs and the top level in rtl/ import this package.
package rba_pkg;

    // Sizing
    localparam int PAGE_COUNT     = 8192;
    localparam int COUNT_BITS     = 16;
    localparam int WORD_BITS      = 64;
    localparam int WORD_COUNT     = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int CHUNK_COUNT    = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int CHUNK_BITS     = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int BIT_IDX_BITS   = $clog2(WORD_BITS);
    localparam int WORD_ADDR_BITS = CHUNK_BITS + BIT_IDX_BITS;
    localparam int PAGE_W         = WORD_ADDR_BITS + BIT_IDX_BITS;
    localparam int PAGE_ADDR_BITS = $clog2(PAGE_COUNT);

    // Port field widths
    localparam int MODE_W   = 2;
    localparam int PAGE_F_W = 13;
    localparam int CNT_F_W  = 16;
    localparam int STAT_W   = 3;

    // Register indexes on the configuration port
    localparam logic CFG_RES_FIRST = 1'b0;
    localparam logic CFG_RES_LAST  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_ADDREF = 2'd2,
        MODE_SEED   = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_OOM   = 3'd1,
        STAT_UNDER = 3'd2,
        STAT_SAT   = 3'd3,
        STAT_IGN   = 3'd4
    } status_t;

    // Result of the find-lowest-set unit
    typedef struct packed {
        logic                    found;
        logic [BIT_IDX_BITS-1:0] idx;
    } ffs_res_t;

endpackage

// ===== rtl/rba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the free bitmap words and the reference counts.
module rba_ram #(
    parameter int DEPTH     = 128,
    parameter int WIDTH     = 64,
    parameter int ADDR_BITS = 7
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rba_ffs.sv =====
// Shared find-lowest-set-bit unit over one bitmap or summary word.
// Depends on rba_pkg for the word size and result struct.
module rba_ffs (
    input  logic [rba_pkg::WORD_BITS-1:0] word,
    output rba_pkg::ffs_res_t             res
);
    import rba_pkg::*;

    // halving search: six narrowing steps on a 64-bit word
    always_comb
    begin
        logic [WORD_BITS-1:0]    v;
        logic [WORD_BITS-1:0]    mask;
        logic [BIT_IDX_BITS-1:0] idx;
        v   = word;
        idx = '0;
        for (int lvl = BIT_IDX_BITS - 1; lvl >= 0; lvl--)
        begin
            mask = (WORD_BITS'(1) << (1 << lvl)) - WORD_BITS'(1);
            if ((v & mask) == '0)
            begin
                idx[lvl] = 1'b1;
                v        = v >> (1 << lvl);
            end
        end
        res.found = |word;
        res.idx   = idx;
    end

endmodule

// ===== rtl/refcounted_bitmap_page_allocator.sv =====
// Top level of the reference-counted bitmap page allocator: sequencer,
// summary flops, output register. Uses rba_pkg, rba_ram and rba_ffs.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+-----------------------------------
//  s_      | in  | s_tvalid/s_tready  | request word: mode, page
//  m_      | out | m_tvalid/m_tready  | result word: page, count, status
//  cfg_    | in  | cfg_valid/cfg_ready| reserved window registers
//
// Free, add-reference and seed pass through accept, memory read and update,
// and hand-off to the output register; allocate first walks the summary
// chunks with the shared find-lowest-set unit, then marks and counts a page.
// After reset a clearing pass writes zero to all PAGE_COUNT counts, one a
// cycle, with s_tready low; config writes are taken always.
// A stalled result holds in the output register while the next word is
// accepted; a further result waits until that register drains.
module refcounted_bitmap_page_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // request: tuser[1:0] mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] page, [15:13] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] result_page, [28:13] count_after,
                                   // [29] released, [31:30] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import rba_pkg::*;

    typedef enum logic [5:0] {
        FSM_CLEAR = 6'b000001,
        FSM_IDLE  = 6'b000010,
        FSM_SCAN  = 6'b000100,
        FSM_ALLOC = 6'b001000,
        FSM_OP    = 6'b010000,
        FSM_PUT   = 6'b100000
    } fsm_t;

    fsm_t                                 state_reg, state_next;
    mode_t                                mode_reg, mode_next;
    logic [PAGE_W-1:0]                    page_reg, page_next;
    logic [CHUNK_BITS-1:0]                chunk_reg, chunk_next;
    logic [BIT_IDX_BITS-1:0]              sidx_reg, sidx_next;
    logic [PAGE_ADDR_BITS-1:0]            clr_reg, clr_next;
    logic [CHUNK_COUNT-1:0][WORD_BITS-1:0] sum_reg, sum_next;
    logic [PAGE_F_W-1:0]                  first_reg, first_next;
    logic [PAGE_F_W-1:0]                  last_reg, last_next;

    logic [PAGE_F_W-1:0]                  res_page_reg, res_page_next;
    logic [CNT_F_W-1:0]                   res_cnt_reg, res_cnt_next;
    status_t                              res_stat_reg, res_stat_next;
    logic                                 res_rel_reg, res_rel_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [31:0]                          out_data_reg, out_data_next;
    logic [2:0]                           out_user_reg, out_user_next;

    // memory ports
    logic                                 map_rd_en, map_wr_en;
    logic [WORD_ADDR_BITS-1:0]            map_rd_addr, map_wr_addr;
    logic [WORD_BITS-1:0]                 map_rd_data, map_wr_data;
    logic                                 cnt_rd_en, cnt_wr_en;
    logic [PAGE_ADDR_BITS-1:0]            cnt_rd_addr, cnt_wr_addr;
    logic [COUNT_BITS-1:0]                cnt_rd_data, cnt_wr_data;

    // shared search unit
    logic [WORD_BITS-1:0]                 ffs_word;
    ffs_res_t                             ffs_res;

    logic                                 in_acc;
    logic [PAGE_W-1:0]                    in_page;

    rba_ram #(
        .DEPTH     (WORD_COUNT),
        .WIDTH     (WORD_BITS),
        .ADDR_BITS (WORD_ADDR_BITS)
    ) u_map_ram (
        .clk     (clk),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    rba_ram #(
        .DEPTH     (PAGE_COUNT),
        .WIDTH     (COUNT_BITS),
        .ADDR_BITS (PAGE_ADDR_BITS)
    ) u_cnt_ram (
        .clk     (clk),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data)
    );

    rba_ffs u_ffs (
        .word (ffs_word),
        .res  (ffs_res)
    );

    assign s_tready  = (state_reg == FSM_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign in_page   = PAGE_W'(s_tdata[PAGE_F_W-1:0]);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // search unit input: summary chunk while scanning, bitmap word otherwise
    assign ffs_word = (state_reg == FSM_SCAN) ? sum_reg[chunk_reg] : map_rd_data;

    // sequencer
    always_comb
    begin
        logic [WORD_BITS-1:0]    word;
        logic [WORD_BITS-1:0]    bitmask;
        logic [COUNT_BITS-1:0]   c;
        logic [COUNT_BITS-1:0]   c_adj;
        logic                    sum_bit;
        logic                    in_window;
        logic [PAGE_W-1:0]       found_pg;
        logic [CHUNK_BITS-1:0]   pg_chunk;
        logic [BIT_IDX_BITS-1:0] pg_slot;

        state_next     = state_reg;
        mode_next      = mode_reg;
        page_next      = page_reg;
        chunk_next     = chunk_reg;
        sidx_next      = sidx_reg;
        clr_next       = clr_reg;
        sum_next       = sum_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        res_page_next  = res_page_reg;
        res_cnt_next   = res_cnt_reg;
        res_stat_next  = res_stat_reg;
        res_rel_next   = res_rel_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        map_rd_en   = 1'b0;
        map_rd_addr = page_reg[PAGE_W-1:BIT_IDX_BITS];
        map_wr_en   = 1'b0;
        map_wr_addr = page_reg[PAGE_W-1:BIT_IDX_BITS];
        map_wr_data = '0;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = PAGE_ADDR_BITS'(page_reg);
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = PAGE_ADDR_BITS'(page_reg);
        cnt_wr_data = '0;

        // bitmap word of the current page; an empty summary bit means zero
        pg_chunk  = page_reg[PAGE_W-1:PAGE_W-CHUNK_BITS];
        pg_slot   = page_reg[PAGE_W-CHUNK_BITS-1:BIT_IDX_BITS];
        sum_bit   = sum_reg[pg_chunk][pg_slot];
        word      = sum_bit ? map_rd_data : '0;
        bitmask   = WORD_BITS'(1) << page_reg[BIT_IDX_BITS-1:0];
        c         = cnt_rd_data;
        c_adj     = c + ((mode_reg == MODE_ADDREF) ? COUNT_BITS'(1) : '1);
        in_window = (page_reg >= PAGE_W'(first_reg)) && (page_reg <= PAGE_W'(last_reg));
        found_pg  = {chunk_reg, sidx_reg, ffs_res.idx};

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RES_FIRST: first_next = cfg_data;
                CFG_RES_LAST:  last_next  = cfg_data;
                default:       first_next = first_reg;
            endcase
        end

        // output register drains
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_CLEAR:
            begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = clr_reg;
                clr_next    = clr_reg + PAGE_ADDR_BITS'(1);
                if (clr_reg == PAGE_ADDR_BITS'(PAGE_COUNT - 1))
                begin
                    state_next = FSM_IDLE;
                end
            end

            FSM_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next  = mode_t'(s_tuser);
                    page_next  = in_page;
                    chunk_next = '0;
                    if (mode_t'(s_tuser) == MODE_ALLOC)
                    begin
                        state_next = FSM_SCAN;
                    end
                    else if (32'(s_tdata[PAGE_F_W-1:0]) >= 32'(PAGE_COUNT))
                    begin
                        res_page_next = s_tdata[PAGE_F_W-1:0];
                        res_cnt_next  = '0;
                        res_stat_next = STAT_IGN;
                        res_rel_next  = 1'b0;
                        state_next    = FSM_PUT;
                    end
                    else
                    begin
                        map_rd_en   = 1'b1;
                        map_rd_addr = in_page[PAGE_W-1:BIT_IDX_BITS];
                        cnt_rd_en   = 1'b1;
                        cnt_rd_addr = PAGE_ADDR_BITS'(in_page);
                        state_next  = FSM_OP;
                    end
                end
            end

            // walk the summary one chunk a cycle
            FSM_SCAN:
            begin
                if (ffs_res.found)
                begin
                    sidx_next   = ffs_res.idx;
                    map_rd_en   = 1'b1;
                    map_rd_addr = {chunk_reg, ffs_res.idx};
                    state_next  = FSM_ALLOC;
                end
                else if (chunk_reg == CHUNK_BITS'(CHUNK_COUNT - 1))
                begin
                    res_page_next = '0;
                    res_cnt_next  = '0;
                    res_stat_next = STAT_OOM;
                    res_rel_next  = 1'b0;
                    state_next    = FSM_PUT;
                end
                else
                begin
                    chunk_next = chunk_reg + CHUNK_BITS'(1);
                end
            end

            // lowest bit of the chosen word, mark used, count one
            FSM_ALLOC:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = {chunk_reg, sidx_reg};
                map_wr_data = map_rd_data & ~(WORD_BITS'(1) << ffs_res.idx);
                sum_next[chunk_reg][sidx_reg] = |map_wr_data;
                cnt_wr_en     = 1'b1;
                cnt_wr_addr   = PAGE_ADDR_BITS'(found_pg);
                cnt_wr_data   = COUNT_BITS'(1);
                res_page_next = PAGE_F_W'(found_pg);
                res_cnt_next  = CNT_F_W'(1);
                res_stat_next = STAT_OK;
                res_rel_next  = 1'b0;
                state_next    = FSM_PUT;
            end

            // free, add reference, seed on data read at accept
            FSM_OP:
            begin
                res_page_next = PAGE_F_W'(page_reg);
                res_rel_next  = 1'b0;
                res_cnt_next  = CNT_F_W'(c);
                res_stat_next = STAT_OK;
                map_wr_data   = word | bitmask;
                unique case (mode_reg)
                    MODE_FREE:
                    begin
                        if (page_reg == '0)
                        begin
                            res_stat_next = STAT_IGN;
                        end
                        else if (c == '0)
                        begin
                            res_stat_next = STAT_UNDER;
                        end
                        else
                        begin
                            cnt_wr_en    = 1'b1;
                            cnt_wr_data  = c_adj;
                            res_cnt_next = CNT_F_W'(c_adj);
                            if (c_adj == '0)
                            begin
                                map_wr_en    = 1'b1;
                                res_rel_next = 1'b1;
                                sum_next[pg_chunk][pg_slot] = 1'b1;
                            end
                        end
                    end
                    MODE_ADDREF:
                    begin
                        if (&c)
                        begin
                            res_stat_next = STAT_SAT;
                        end
                        else
                        begin
                            cnt_wr_en    = 1'b1;
                            cnt_wr_data  = c_adj;
                            res_cnt_next = CNT_F_W'(c_adj);
                        end
                    end
                    MODE_SEED:
                    begin
                        if (in_window)
                        begin
                            res_stat_next = STAT_IGN;
                        end
                        else
                        begin
                            map_wr_en = 1'b1;
                            sum_next[pg_chunk][pg_slot] = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_stat_next = STAT_IGN;
                    end
                endcase
                state_next = FSM_PUT;
            end

            // hand the result to the output register once it is free
            FSM_PUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, res_rel_reg, res_cnt_reg, res_page_reg};
                    out_user_next  = res_stat_reg;
                    state_next     = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_CLEAR;
            clr_reg       <= '0;
            sum_reg       <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sum_reg       <= sum_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        page_reg     <= page_next;
        chunk_reg    <= chunk_next;
        sidx_reg     <= sidx_next;
        res_page_reg <= res_page_next;
        res_cnt_reg  <= res_cnt_next;
        res_stat_reg <= res_stat_next;
        res_rel_reg  <= res_rel_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

`ifndef SYNTHESIS
    // nothing is taken in while the counts are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_CLEAR) |-> !s_tready)
        else $error("request accepted during clearing pass");

    // an accepted word always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != FSM_IDLE))
        else $error("sequencer stayed idle after accept");

    // a waiting result is never overwritten by the next one
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> ($stable(out_data_reg) && $stable(out_user_reg)))
        else $error("stalled result overwritten");

    // a release always reports count zero and success
    a_release_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[29]) |->
            ((out_data_reg[28:13] == '0) && (out_user_reg == STAT_OK)))
        else $error("release with nonzero count or bad status");
`endif

endmodule

// ===== tb/rba_reply_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the reference-counted page allocator: watches the request,
// result and configuration channels, predicts each result word and compares it.
// Depends on rba_pkg for widths, mode and status codes and register indexes.
module rba_reply_checker
    import rba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] page, [15:13] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [12:0] result_page, [28:13] count_after,
                                   // [29] released, [31:30] zero
    input  logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output logic [31:0] mismatch_total,
    output logic [31:0] pending,
    output logic [31:0] checked
);

    localparam logic [COUNT_BITS-1:0] REF_CEILING = '1;

    typedef struct packed {
        logic [PAGE_F_W-1:0] page;
        logic [CNT_F_W-1:0]  count;
        status_t             status;
        logic                released;
    } page_reply_t;

    // Shadow of the allocator state
    logic                  page_free [PAGE_COUNT];
    logic [COUNT_BITS-1:0] page_refs [PAGE_COUNT];
    logic [PAGE_F_W-1:0]   window_first;
    logic [PAGE_F_W-1:0]   window_last;

    page_reply_t replies_due [$];
    page_reply_t want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        mismatch_total = mismatch_total + 1;
        $display("checker: result word %0d: %s got %0h, want %0h", checked, what, got,
                 wanted);
    endtask

    // Applies one request word to the shadow state and returns its result
    function automatic page_reply_t serve_request(input logic [MODE_W-1:0] md,
                                                  input logic [PAGE_F_W-1:0] pg);
        page_reply_t           r;
        logic                  found;
        logic [PAGE_F_W-1:0]   lowest;
        logic [COUNT_BITS-1:0] c;
        r          = '0;
        r.page     = pg;
        r.status   = STAT_OK;
        found      = 1'b0;
        lowest     = '0;
        if (md == MODE_ALLOC)
        begin
            for (int i = 0; i < PAGE_COUNT && !found; i++)
            begin
                if (page_free[i])
                begin
                    found  = 1'b1;
                    lowest = PAGE_F_W'(i);
                end
            end
            if (!found)
            begin
                r.page   = '0;
                r.status = STAT_OOM;
            end
            else
            begin
                page_free[lowest] = 1'b0;
                page_refs[lowest] = COUNT_BITS'(1);
                r.page            = lowest;
                r.count           = CNT_F_W'(1);
            end
        end
        else if (pg >= PAGE_COUNT)
        begin
            r.status = STAT_IGN;
        end
        else
        begin
            c = page_refs[pg];
            case (md)
                MODE_FREE:
                begin
                    if (pg == 0)
                    begin
                        r.count  = c;
                        r.status = STAT_IGN;
                    end
                    else if (c == 0)
                        r.status = STAT_UNDER;
                    else
                    begin
                        c             = c - COUNT_BITS'(1);
                        page_refs[pg] = c;
                        r.count       = c;
                        if (c == 0)
                        begin
                            page_free[pg] = 1'b1;
                            r.released    = 1'b1;
                        end
                    end
                end
                MODE_ADDREF:
                begin
                    if (c == REF_CEILING)
                    begin
                        r.count  = c;
                        r.status = STAT_SAT;
                    end
                    else
                    begin
                        c             = c + COUNT_BITS'(1);
                        page_refs[pg] = c;
                        r.count       = c;
                    end
                end
                default:
                begin
                    // seed: the window is inclusive, empty when first > last
                    r.count = c;
                    if (pg >= window_first && pg <= window_last)
                        r.status = STAT_IGN;
                    else
                        page_free[pg] = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    // Channel monitor: results are compared before the same edge's request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                page_free[i] = 1'b0;
                page_refs[i] = '0;
            end
            window_first   = '0;
            window_last    = '0;
            replies_due.delete();
            mismatch_total = 0;
            pending        = 0;
            checked        = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("result word with nothing due", m_tdata, 0);
                else
                begin
                    want = replies_due.pop_front();
                    if (m_tdata[12:0] !== want.page)
                        report_mismatch("result_page", 32'(m_tdata[12:0]),
                                        32'(want.page));
                    if (m_tdata[28:13] !== want.count)
                        report_mismatch("count_after", 32'(m_tdata[28:13]),
                                        32'(want.count));
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[29] !== want.released)
                        report_mismatch("released", 32'(m_tdata[29]),
                                        32'(want.released));
                    checked = checked + 1;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RES_FIRST)
                    window_first = cfg_data;
                else
                    window_last = cfg_data;
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(serve_request(s_tuser, s_tdata[12:0]));
            pending = replies_due.size();
        end
    end

endmodule

// ===== tb/refcounted_bitmap_page_allocator_test.sv =====
`timescale 1ns / 100ps
// Top of the page allocator testbench: clock, reset, request and receiver
// drivers, window register writes, watchdog and verdict.
// Depends on rba_pkg, the allocator RTL and rba_reply_checker.
module refcounted_bitmap_page_allocator_test;
    import rba_pkg::*;

    localparam int QUIET_LIMIT  = 50000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 112;
    localparam int PHASES       = 8;
    localparam int RAMP_WORDS   = 12;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;

    logic [31:0] mismatch_total;
    logic [31:0] pending;
    logic [31:0] checked;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        long_hold     = 1'b0;
    int          quiet_cycles  = 0;
    int          window_writes = 0;
    int          sent_by_mode [4];

    refcounted_bitmap_page_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rba_reply_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_total (mismatch_total),
        .pending        (pending),
        .checked        (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("refcounted_bitmap_page_allocator_test: done, errors");
                $finish;
            end
        end
    end

    // Offers one request word; entered and left at a falling edge.
    // Valid stays high on return so back-to-back words keep it up.
    task automatic send_word(input mode_t md, input logic [12:0] pg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, pg};
        s_tuser  = md;
        do @(posedge clk); while (!s_tready);
        sent_by_mode[md]++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Drains all outstanding results, then sets the reserved window
    task automatic set_window(input logic [12:0] first, input logic [12:0] last);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        write_reg(CFG_RES_FIRST, first);
        write_reg(CFG_RES_LAST, last);
        cfg_valid = 1'b0;
        window_writes++;
    endtask

    // Mostly a small pool near page 0 so counts and frees interact
    function automatic logic [12:0] pick_page();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 13'($urandom_range(47));
        else if (r < 85)
            return 13'd8191 - 13'($urandom_range(31));
        return 13'($urandom);
    endfunction

    task automatic send_random_word();
        int unsigned r;
        mode_t       md;
        r = $urandom_range(99);
        if (r < 30)
            md = MODE_ALLOC;
        else if (r < 60)
            md = MODE_FREE;
        else if (r < 75)
            md = MODE_ADDREF;
        else
            md = MODE_SEED;
        send_word(md, pick_page());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_ALLOC;
        cfg_valid = 1'b0;
        cfg_index = CFG_RES_FIRST;
        cfg_data  = '0;
        for (int i = 0; i < 4; i++)
            sent_by_mode[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pool, ignored and underflowing frees, seeding rules
        set_window(13'd0, 13'd0);
        send_word(MODE_ALLOC, 13'd0);       // out of memory
        send_word(MODE_FREE, 13'd0);        // page zero ignored
        send_word(MODE_FREE, 13'd1);        // underflow
        send_word(MODE_ADDREF, 13'd1);
        send_word(MODE_SEED, 13'd0);        // inside window
        send_word(MODE_SEED, 13'd1);        // seeded with a live count
        send_word(MODE_SEED, 13'd1);        // already free
        send_word(MODE_ALLOC, 13'd8191);
        send_word(MODE_ADDREF, 13'd1);
        send_word(MODE_FREE, 13'd1);
        send_word(MODE_FREE, 13'd1);        // released
        send_word(MODE_SEED, 13'd8191);
        send_word(MODE_ALLOC, 13'd0);
        send_word(MODE_ALLOC, 13'd0);
        send_word(MODE_ALLOC, 13'd0);       // out of memory again
        send_word(MODE_ADDREF, 13'd8191);
        send_word(MODE_FREE, 13'd8191);
        send_word(MODE_FREE, 13'd8191);
        send_word(MODE_ADDREF, 13'd0);
        send_word(MODE_FREE, 13'd0);        // page zero with a count
        set_window(13'd8, 13'd15);
        send_word(MODE_SEED, 13'd8);
        send_word(MODE_SEED, 13'd15);
        send_word(MODE_SEED, 13'd7);
        send_word(MODE_SEED, 13'd16);
        set_window(13'd16, 13'd8);          // empty window
        send_word(MODE_SEED, 13'd12);

        // Short count ramp on one page, then a free
        set_window(13'd0, 13'd0);
        for (int i = 0; i < RAMP_WORDS; i++)
            send_word(MODE_ADDREF, 13'd4000);
        send_word(MODE_FREE, 13'd4000);

        // Random phases across window settings and idling patterns
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       set_window(13'd16, 13'd31);
                1:       set_window(13'd0, 13'd8191);
                2:       set_window(13'd8191, 13'd0);
                4:       set_window(13'd8191, 13'd8191);
                5:       set_window(13'd0, 13'd0);
                7:       set_window(13'd40, 13'd8191);
                default: set_window(13'($urandom), 13'($urandom_range(63)));
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 58;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 58;
                end
                default:
                begin
                    send_idle_pct = 32;
                    stall_pct     = 32;
                end
            endcase
            // first phase: receiver holds off while words keep coming
            if (phase == 0)
                long_hold = 1'b1;
            repeat (PHASE_WORDS) send_random_word();
            s_tvalid = 1'b0;
        end

        stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(posedge clk);

        $display("summary: %0d request words (alloc %0d, free %0d, add-ref %0d, seed %0d)",
                 sent_by_mode[MODE_ALLOC] + sent_by_mode[MODE_FREE] +
                 sent_by_mode[MODE_ADDREF] + sent_by_mode[MODE_SEED],
                 sent_by_mode[MODE_ALLOC], sent_by_mode[MODE_FREE],
                 sent_by_mode[MODE_ADDREF], sent_by_mode[MODE_SEED]);
        $display("summary: %0d result words compared over %0d window settings",
                 checked, window_writes);
        if (mismatch_total == 0)
            $display("refcounted_bitmap_page_allocator_test: done, clean");
        else
            $display("refcounted_bitmap_page_allocator_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rba_pkg.sv
rtl/rba_ram.sv
rtl/rba_ffs.sv
rtl/refcounted_bitmap_page_allocator.sv
tb/rba_reply_checker.sv
tb/refcounted_bitmap_page_allocator_test.sv
